/* sv/cau_pkg.sv */
// Package for the complex arithmetic unit: widths, command and status codes, types.
// No dependencies.
`timescale 1ns / 1ps
package cau_pkg;
    localparam int DEF_DATA_WIDTH = 16;
    localparam int DEF_FRAC_BITS  = 8;
    localparam int TOL_W          = 15;
    localparam int CMD_W          = 3;
    localparam int STATUS_W       = 2;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_CONJ = 3'd4,
        CMD_CMP = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;
endpackage

/* sv/cau_if.sv */
// Valid/ready channel interfaces for operand items, result items and configuration.
// No dependencies.
`timescale 1ns / 1ps
interface cau_in_if #(parameter int DW = 16);
    logic                  valid;
    logic                  ready;
    logic [2:0]            command;
    logic signed [DW-1:0]  a_re;
    logic signed [DW-1:0]  a_im;
    logic signed [DW-1:0]  b_re;
    logic signed [DW-1:0]  b_im;
    modport source (output valid, command, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, command, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if #(parameter int DW = 16);
    logic                  valid;
    logic                  ready;
    logic signed [DW-1:0]  result_re;
    logic signed [DW-1:0]  result_im;
    logic                  is_equal;
    logic [1:0]            status;
    modport source (output valid, result_re, result_im, is_equal, status, input ready);
    modport sink   (input valid, result_re, result_im, is_equal, status, output ready);
endinterface

interface cau_cfg_if;
    logic        valid;
    logic        ready;
    logic [14:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* sv/cau_front.sv */
// Front end: accepts items, computes products and sums, resolves simple commands.
// Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_front
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int PW         = 2 * DATA_WIDTH + 1
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [CMD_W-1:0]             command,
    input  logic signed [DATA_WIDTH-1:0] a_re,
    input  logic signed [DATA_WIDTH-1:0] a_im,
    input  logic signed [DATA_WIDTH-1:0] b_re,
    input  logic signed [DATA_WIDTH-1:0] b_im,
    input  logic [TOL_W-1:0]             tol,
    output logic                         f_valid,
    input  logic                         f_ready,
    output logic [CMD_W-1:0]             f_cmd,
    output logic signed [PW-1:0]         f_x,
    output logic signed [PW-1:0]         f_y,
    output logic [PW-1:0]                f_den,
    output logic signed [DATA_WIDTH-1:0] f_re,
    output logic signed [DATA_WIDTH-1:0] f_im,
    output logic                         f_eq,
    output logic [STATUS_W-1:0]          f_st
);
    localparam int DW = DATA_WIDTH;
    localparam logic signed [DW+1:0] SMAX = (DW+2)'((1 << (DW-1)) - 1);
    localparam logic signed [DW+1:0] SMIN = -SMAX - (DW+2)'(1);

    // stage 1: products
    logic                      s1_v_reg;
    logic [CMD_W-1:0]          s1_cmd_reg;
    logic signed [DW-1:0]      s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;
    logic signed [2*DW-1:0]    p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_reg, p_cc_reg;
    logic                      adv;

    assign adv      = !f_valid || f_ready;
    assign in_ready = adv || !s1_v_reg;
    logic s1_adv;
    assign s1_adv = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (s1_adv)
            s1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && in_valid)
        begin
            s1_cmd_reg <= command;
            s1_ar_reg <= a_re; s1_ai_reg <= a_im;
            s1_br_reg <= b_re; s1_bi_reg <= b_im;
            p_rr_reg <= a_re * b_re;
            p_ii_reg <= a_im * b_im;
            p_ri_reg <= a_re * b_im;
            p_ir_reg <= a_im * b_re;
            p_bb_reg <= b_re * b_re;
            p_cc_reg <= b_im * b_im;
        end
    end

    // stage 2: sums and simple results
    logic signed [PW-1:0]   x_next, y_next;
    logic [PW-1:0]          den_next;
    logic signed [DW-1:0]   re_next, im_next;
    logic                   eq_next, satf;
    logic [STATUS_W-1:0]    st_next;
    logic signed [DW+1:0]   t_re, t_im;
    logic signed [PW:0]     sh_re, sh_im;
    logic [DW:0]            d_re, d_im;

    function automatic logic signed [DW-1:0] sat_n(input logic signed [DW+1:0] v,
                                                    output logic f);
        f = 1'b0;
        if (v > SMAX) begin f = 1'b1; return SMAX[DW-1:0]; end
        if (v < SMIN) begin f = 1'b1; return SMIN[DW-1:0]; end
        return v[DW-1:0];
    endfunction

    function automatic logic [DW:0] absd(input logic signed [DW-1:0] p,
                                         input logic signed [DW-1:0] q);
        logic signed [DW+1:0] d;
        d = (DW+2)'(p) - (DW+2)'(q);
        return d[DW+1] ? (DW+1)'(-d) : (DW+1)'(d);
    endfunction

    function automatic logic signed [DW-1:0] sat_w(input logic signed [PW:0] v,
                                                   output logic f);
        f = 1'b0;
        if (v > (PW+1)'(SMAX)) begin f = 1'b1; return SMAX[DW-1:0]; end
        if (v < (PW+1)'(SMIN)) begin f = 1'b1; return SMIN[DW-1:0]; end
        return v[DW-1:0];
    endfunction

    always_comb
    begin
        logic f1, f2;
        f1 = 1'b0; f2 = 1'b0;
        x_next   = PW'(p_rr_reg) + PW'(p_ii_reg);
        y_next   = PW'(p_ir_reg) - PW'(p_ri_reg);
        den_next = PW'(p_bb_reg) + PW'(p_cc_reg);
        re_next  = '0; im_next = '0; eq_next = 1'b0; st_next = ST_OK;
        t_re = '0; t_im = '0;
        sh_re = ((PW+1)'(p_rr_reg) - (PW+1)'(p_ii_reg)) >>> FRAC_BITS;
        sh_im = ((PW+1)'(p_ri_reg) + (PW+1)'(p_ir_reg)) >>> FRAC_BITS;
        d_re = absd(s1_ar_reg, s1_br_reg);
        d_im = absd(s1_ai_reg, s1_bi_reg);
        case (s1_cmd_reg)
            CMD_ADD:
            begin
                t_re = (DW+2)'(s1_ar_reg) + (DW+2)'(s1_br_reg);
                t_im = (DW+2)'(s1_ai_reg) + (DW+2)'(s1_bi_reg);
                re_next = sat_n(t_re, f1); im_next = sat_n(t_im, f2);
            end
            CMD_SUB:
            begin
                t_re = (DW+2)'(s1_ar_reg) - (DW+2)'(s1_br_reg);
                t_im = (DW+2)'(s1_ai_reg) - (DW+2)'(s1_bi_reg);
                re_next = sat_n(t_re, f1); im_next = sat_n(t_im, f2);
            end
            CMD_MUL:
            begin
                re_next = sat_w(sh_re, f1); im_next = sat_w(sh_im, f2);
            end
            CMD_CONJ:
            begin
                t_im = -(DW+2)'(s1_ai_reg);
                re_next = s1_ar_reg; im_next = sat_n(t_im, f2);
            end
            CMD_CMP:
                eq_next = ((DW+TOL_W+1)'(d_re) < (DW+TOL_W+1)'(tol)) &&
                          ((DW+TOL_W+1)'(d_im) < (DW+TOL_W+1)'(tol));
            default: ;
        endcase
        satf = f1 | f2;
        if (satf)
            st_next = ST_SAT;
    end

    logic f_valid_reg;
    assign f_valid = f_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (adv)
            f_valid_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_v_reg)
        begin
            f_cmd <= s1_cmd_reg; f_x <= x_next; f_y <= y_next; f_den <= den_next;
            f_re <= re_next; f_im <= im_next; f_eq <= eq_next; f_st <= st_next;
        end
    end
endmodule

/* sv/cau_fifo.sv */
// Short queue between front and back end; entries are packed words.
// No dependencies.
`timescale 1ns / 1ps
module cau_fifo #(
    parameter int W     = 32,
    parameter int DEPTH = 4
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);
    localparam int AW = $clog2(DEPTH);
    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          wr, rd;

    assign wr_ready = cnt_reg != (AW+1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (rd) rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end
endmodule

/* sv/cau_back.sv */
// Back end: pipelined restoring divider for the divide command, output register.
// Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_back
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int PW         = 2 * DATA_WIDTH + 1
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         b_valid,
    output logic                         b_ready,
    input  logic [CMD_W-1:0]             b_cmd,
    input  logic signed [PW-1:0]         b_x,
    input  logic signed [PW-1:0]         b_y,
    input  logic [PW-1:0]                b_den,
    input  logic signed [DATA_WIDTH-1:0] b_re,
    input  logic signed [DATA_WIDTH-1:0] b_im,
    input  logic                         b_eq,
    input  logic [STATUS_W-1:0]          b_st,
    output logic                         o_valid,
    input  logic                         o_ready,
    output logic signed [DATA_WIDTH-1:0] o_re,
    output logic signed [DATA_WIDTH-1:0] o_im,
    output logic                         o_eq,
    output logic [STATUS_W-1:0]          o_st
);
    localparam int DW = DATA_WIDTH;
    // numerator magnitude |x| * 2^F, quotient kept to QB bits then saturated
    localparam int NW = PW + FRAC_BITS;
    localparam int QB = DW + 1;          // bits kept above (quotient >= 2^DW saturates)
    localparam int NS = NW;              // one quotient bit per stage
    localparam logic [DW-1:0] SMAXU = DW'((1 << (DW-1)) - 1);

    typedef struct packed {
        logic [NW-1:0]  nre;    // remaining numerator bits (shifted out MSB first)
        logic [NW-1:0]  nim;
        logic [PW:0]    rre;    // partial remainder
        logic [PW:0]    rim;
        logic [QB-1:0]  qre;
        logic [QB-1:0]  qim;
        logic           ovre;
        logic           ovim;
        logic           sre;
        logic           sim;
        logic [PW-1:0]  den;
        logic           div;
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic           eq;
        logic [STATUS_W-1:0] st;
    } stg_t;

    stg_t           pipe_reg [NS+1];
    logic [NS:0]    v_reg;
    logic           adv;

    assign adv     = !o_valid || o_ready;
    assign b_ready = adv;

    stg_t s0;
    always_comb
    begin
        logic [PW-1:0] mx, my;
        mx = b_x[PW-1] ? PW'(-b_x) : PW'(b_x);
        my = b_y[PW-1] ? PW'(-b_y) : PW'(b_y);
        s0 = '0;
        s0.nre = NW'(mx) << FRAC_BITS;
        s0.nim = NW'(my) << FRAC_BITS;
        s0.sre = b_x[PW-1];
        s0.sim = b_y[PW-1];
        s0.den = b_den;
        s0.div = (b_cmd == CMD_DIV) && (b_den != '0);
        s0.re  = b_re; s0.im = b_im; s0.eq = b_eq;
        s0.st  = (b_cmd == CMD_DIV && b_den == '0) ? ST_DIV0 : b_st;
        if (b_cmd == CMD_DIV) begin s0.re = '0; s0.im = '0; end
    end

    function automatic stg_t step(input stg_t s);
        stg_t o;
        logic [PW+1:0] tr, ti;
        o = s;
        tr = {s.rre, s.nre[NW-1]} - (PW+2)'(s.den);
        ti = {s.rim, s.nim[NW-1]} - (PW+2)'(s.den);
        o.nre = s.nre << 1;
        o.nim = s.nim << 1;
        o.ovre = s.ovre | s.qre[QB-1];
        o.ovim = s.ovim | s.qim[QB-1];
        if (!tr[PW+1]) o.rre = tr[PW:0]; else o.rre = {s.rre[PW-1:0], s.nre[NW-1]};
        if (!ti[PW+1]) o.rim = ti[PW:0]; else o.rim = {s.rim[PW-1:0], s.nim[NW-1]};
        o.qre = {s.qre[QB-2:0], !tr[PW+1]};
        o.qim = {s.qim[QB-2:0], !ti[PW+1]};
        return o;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NS-1:0], b_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pipe_reg[0] <= s0;
            for (int i = 1; i <= NS; i++)
                pipe_reg[i] <= step(pipe_reg[i-1]);
        end
    end

    // final: sign and saturate
    stg_t e;
    logic signed [DW-1:0] re_f, im_f;
    logic [STATUS_W-1:0]  st_f;
    function automatic logic [DW-1:0] fin(input logic [QB-1:0] q, input logic ov,
                                          input logic sg, output logic f);
        f = 1'b0;
        if (sg)
        begin
            if (ov || q > QB'(SMAXU) + QB'(1)) begin f = 1'b1; return ~SMAXU; end
            return DW'(-q);
        end
        if (ov || q > QB'(SMAXU)) begin f = 1'b1; return SMAXU; end
        return q[DW-1:0];
    endfunction

    always_comb
    begin
        logic f1, f2;
        e = pipe_reg[NS];
        f1 = 1'b0; f2 = 1'b0;
        re_f = e.re; im_f = e.im; st_f = e.st;
        if (e.div)
        begin
            re_f = fin(e.qre, e.ovre, e.sre, f1);
            im_f = fin(e.qim, e.ovim, e.sim, f2);
            if (f1 | f2) st_f = ST_SAT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid <= 1'b0;
        else if (adv)
            o_valid <= v_reg[NS];
    end

    always_ff @(posedge clk)
    begin
        if (adv && v_reg[NS])
        begin
            o_re <= re_f; o_im <= im_f; o_eq <= e.eq; o_st <= st_f;
        end
    end
endmodule

/* sv/complex_arithmetic_unit.sv */
// Complex-number ALU, signed fixed point (Q8.8 by default).
// Channels: in (command, a_re, a_im, b_re, b_im), out (result_re, result_im,
// is_equal, status), cfg (equal_tolerance write data), all valid/ready.
// An item is taken when valid and ready are both high; one result per item,
// in order. Throughput is one item per cycle while out.ready stays high.
// Every command passes through the same path, including the bit-per-stage
// divider in the back end.
// Front end: products and simple commands; a four-entry queue decouples it
// from the back end, which holds the divider pipeline and the output register.
// When out.ready is low while a result waits, the back end freezes, the queue
// fills, then the front end freezes and in.ready drops.
// Reset clears all valid flags and sets equal_tolerance to 1; cfg is always ready.
// Depends on cau_pkg, cau_if, cau_front, cau_fifo, cau_back.
`timescale 1ns / 1ps
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)(
    input logic         clk,
    input logic         rst_n,
    cau_in_if.sink      in,
    cau_out_if.source   out,
    cau_cfg_if.sink     cfg
);
    localparam int PW = 2 * DATA_WIDTH + 1;
    localparam int QW = CMD_W + 3 * PW + 2 * DATA_WIDTH + 1 + STATUS_W;

    logic [TOL_W-1:0] tol_reg;
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg.valid)
            tol_reg <= cfg.data;
    end

    logic                         f_valid, f_ready;
    logic [CMD_W-1:0]             f_cmd, q_cmd;
    logic signed [PW-1:0]         f_x, f_y, q_x, q_y;
    logic [PW-1:0]                f_den, q_den;
    logic signed [DATA_WIDTH-1:0] f_re, f_im, q_re, q_im;
    logic                         f_eq, q_eq, q_valid, q_ready;
    logic [STATUS_W-1:0]          f_st, q_st;
    logic [QW-1:0]                q_in, q_out;

    cau_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .PW(PW)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in.valid), .in_ready(in.ready), .command(in.command),
        .a_re(in.a_re), .a_im(in.a_im), .b_re(in.b_re), .b_im(in.b_im),
        .tol(tol_reg),
        .f_valid(f_valid), .f_ready(f_ready), .f_cmd(f_cmd), .f_x(f_x), .f_y(f_y),
        .f_den(f_den), .f_re(f_re), .f_im(f_im), .f_eq(f_eq), .f_st(f_st)
    );

    assign q_in = {f_cmd, f_x, f_y, f_den, f_re, f_im, f_eq, f_st};
    assign {q_cmd, q_x, q_y, q_den, q_re, q_im, q_eq, q_st} = q_out;

    cau_fifo #(.W(QW), .DEPTH(4)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(q_in),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_out)
    );

    cau_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .PW(PW)) u_back (
        .clk(clk), .rst_n(rst_n),
        .b_valid(q_valid), .b_ready(q_ready), .b_cmd(q_cmd), .b_x(q_x), .b_y(q_y),
        .b_den(q_den), .b_re(q_re), .b_im(q_im), .b_eq(q_eq), .b_st(q_st),
        .o_valid(out.valid), .o_ready(out.ready), .o_re(out.result_re),
        .o_im(out.result_im), .o_eq(out.is_equal), .o_st(out.status)
    );
endmodule
